FILE: design/mmwp_pkg.sv
package mmwp_pkg;

    localparam int Wheels      = 4;
    localparam int GainW       = 20;
    localparam int DivSteps    = 14;
    localparam int TargetLimit = 10000;
    localparam int SumLimit    = 100000;
    localparam int OutLimit    = 30000;

    localparam logic signed [GainW-1:0] GainPReset = 20'sd5120;
    localparam logic signed [GainW-1:0] GainIReset = 20'sd0;
    localparam logic signed [GainW-1:0] GainDReset = 20'sd10240;

    localparam logic [1:0] REG_GAIN_P = 2'd0;
    localparam logic [1:0] REG_GAIN_I = 2'd1;
    localparam logic [1:0] REG_GAIN_D = 2'd2;

    typedef struct packed {
        logic signed [15:0] cmd_forward;
        logic signed [15:0] cmd_left;
        logic signed [15:0] cmd_yaw;
        logic signed [15:0] base_one;
        logic signed [15:0] base_two;
        logic signed [15:0] base_three;
        logic signed [15:0] base_four;
        logic signed [15:0] speed_one;
        logic signed [15:0] speed_two;
        logic signed [15:0] speed_three;
        logic signed [15:0] speed_four;
    } req_item_t;

    typedef struct packed {
        logic signed [15:0] drive_one;
        logic signed [15:0] drive_two;
        logic signed [15:0] drive_three;
        logic signed [15:0] drive_four;
    } rsp_item_t;

    typedef struct packed {
        logic signed [GainW-1:0] gain_p;
        logic signed [GainW-1:0] gain_i;
        logic signed [GainW-1:0] gain_d;
    } gains_t;

    typedef struct packed {
        logic capture;
        logic mix;
        logic div_step;
        logic err;
        logic diff;
        logic prod;
        logic sum;
        logic fin;
    } lane_ctrl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MIX,
        ST_DIV,
        ST_ERR,
        ST_DIFF,
        ST_PROD,
        ST_SUM,
        ST_FIN,
        ST_OUT
    } state_t;

    // wheels one and two subtract forward, wheels two and four subtract left
    function automatic logic fwd_neg(input int lane);
        return lane < 2;
    endfunction

    function automatic logic left_neg(input int lane);
        return (lane % 2) == 1;
    endfunction

endpackage

FILE: design/mecanum_mix_wheel_pid_core.sv
// one item in flight; a new item is taken only in the idle state, after the previous one
// has gone through the 14-step target divider in each lane and into the output register
// a finished result waits in the output register while the next item is taken
// reset: gains return to 20.0, 0.0 and 40.0, previous errors and error sums clear to zero
module mecanum_mix_wheel_pid_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  mmwp_pkg::req_item_t   req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output mmwp_pkg::rsp_item_t   rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import mmwp_pkg::*;

    state_t      state_reg, state_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [30:0] dsh_reg, dsh_next;
    logic        scale_reg;
    rsp_item_t   rsp_reg;
    logic        rsp_valid_reg, rsp_valid_next;
    lane_ctrl_t  ctrl;
    gains_t      gains;
    logic        load_out;
    logic [Wheels-1:0][17:0]        abs_t;
    logic [Wheels-1:0][15:0]        base_v, speed_v;
    logic signed [Wheels-1:0][15:0] drive_v;
    logic [17:0] maxabs;
    logic        scale;

    mmwp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .gains   (gains)
    );

    assign base_v  = {req.base_four, req.base_three, req.base_two, req.base_one};
    assign speed_v = {req.speed_four, req.speed_three, req.speed_two, req.speed_one};

    for (genvar w = 0; w < Wheels; w++)
    begin : g_lane
        mmwp_lane #(.LANE(w)) u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .cmd_forward (req.cmd_forward),
            .cmd_left    (req.cmd_left),
            .cmd_yaw     (req.cmd_yaw),
            .base        (base_v[w]),
            .speed       (speed_v[w]),
            .dsh         (dsh_reg),
            .scale       (scale_reg),
            .gains       (gains),
            .abs_t       (abs_t[w]),
            .drive       (drive_v[w])
        );
    end

    mmwp_merge u_merge (
        .abs_t  (abs_t),
        .maxabs (maxabs),
        .scale  (scale)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (req_valid) state_next = ST_MIX;
            ST_MIX:  state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == 4'(DivSteps - 1)) state_next = ST_ERR;
            ST_ERR:  state_next = ST_DIFF;
            ST_DIFF: state_next = ST_PROD;
            ST_PROD: state_next = ST_SUM;
            ST_SUM:  state_next = ST_FIN;
            ST_FIN:  state_next = ST_OUT;
            ST_OUT:  if (load_out) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl      = '0;
        req_stall = 1'b1;
        load_out  = 1'b0;
        cnt_next  = cnt_reg;
        dsh_next  = dsh_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall    = 1'b0;
                ctrl.capture = req_valid;
            end
            ST_MIX:
            begin
                ctrl.mix = 1'b1;
                cnt_next = '0;
                dsh_next = 31'(maxabs) << (DivSteps - 1);
            end
            ST_DIV:
            begin
                ctrl.div_step = 1'b1;
                cnt_next      = cnt_reg + 4'd1;
                dsh_next      = dsh_reg >> 1;
            end
            ST_ERR:  ctrl.err  = 1'b1;
            ST_DIFF: ctrl.diff = 1'b1;
            ST_PROD: ctrl.prod = 1'b1;
            ST_SUM:  ctrl.sum  = 1'b1;
            ST_FIN:  ctrl.fin  = 1'b1;
            ST_OUT:  load_out  = !rsp_valid_reg || !rsp_stall;
            default: ctrl      = '0;
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
        if (load_out)
            rsp_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dsh_reg <= dsh_next;
        if (ctrl.mix)
            scale_reg <= scale;
        if (load_out)
        begin
            rsp_reg.drive_one   <= drive_v[0];
            rsp_reg.drive_two   <= drive_v[1];
            rsp_reg.drive_three <= drive_v[2];
            rsp_reg.drive_four  <= drive_v[3];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: design/mmwp_cfg.sv
module mmwp_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output mmwp_pkg::gains_t    gains
);
    import mmwp_pkg::*;

    gains_t gains_reg;
    gains_t gains_next;
    logic   wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign gains  = gains_reg;

    always_comb
    begin
        gains_next = gains_reg;
        if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_GAIN_P: gains_next.gain_p = pwdata[GainW-1:0];
                REG_GAIN_I: gains_next.gain_i = pwdata[GainW-1:0];
                REG_GAIN_D: gains_next.gain_d = pwdata[GainW-1:0];
                default:    gains_next = gains_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_GAIN_P: prdata = 32'(gains_reg.gain_p);
            REG_GAIN_I: prdata = 32'(gains_reg.gain_i);
            REG_GAIN_D: prdata = 32'(gains_reg.gain_d);
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.gain_p <= GainPReset;
            gains_reg.gain_i <= GainIReset;
            gains_reg.gain_d <= GainDReset;
        end
        else
        begin
            gains_reg <= gains_next;
        end
    end

endmodule

FILE: design/mmwp_lane.sv
module mmwp_lane #(
    parameter int LANE = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mmwp_pkg::lane_ctrl_t ctrl,
    input  logic signed [15:0]   cmd_forward,
    input  logic signed [15:0]   cmd_left,
    input  logic signed [15:0]   cmd_yaw,
    input  logic signed [15:0]   base,
    input  logic signed [15:0]   speed,
    input  logic [30:0]          dsh,
    input  logic                 scale,
    input  mmwp_pkg::gains_t     gains,
    output logic [17:0]          abs_t,
    output logic signed [15:0]   drive
);
    import mmwp_pkg::*;

    logic signed [17:0] t_reg, t_next;
    logic signed [15:0] speed_reg;
    logic [30:0]        rem_reg, rem_next;
    logic [13:0]        q_reg, q_next;
    logic signed [16:0] e_reg;
    logic signed [18:0] s_reg;
    logic signed [17:0] de_reg;
    logic signed [36:0] pp_reg;
    logic signed [38:0] pi_reg;
    logic signed [37:0] pd_reg;
    logic signed [40:0] acc_reg;
    logic signed [15:0] drive_reg, drive_next;
    logic signed [16:0] prev_reg;
    logic signed [17:0] sum_reg, sum_next;
    logic signed [17:0] fwd_term, left_term, tq, e_wide;
    logic signed [40:0] acc_adj, qv;

    always_comb
    begin
        fwd_term  = fwd_neg(LANE) ? -18'(cmd_forward) : 18'(cmd_forward);
        left_term = left_neg(LANE) ? -18'(cmd_left) : 18'(cmd_left);
        t_next    = 18'(base) + fwd_term + left_term + 18'(cmd_yaw);
    end

    assign abs_t = t_reg[17] ? 18'(-t_reg) : 18'(t_reg);

    always_comb
    begin
        rem_next = rem_reg;
        q_next   = q_reg;
        if (ctrl.mix)
        begin
            rem_next = 31'(32'(abs_t) * 32'(TargetLimit));
            q_next   = '0;
        end
        else if (ctrl.div_step)
        begin
            if (rem_reg >= dsh)
            begin
                rem_next = rem_reg - dsh;
                q_next   = {q_reg[12:0], 1'b1};
            end
            else
            begin
                q_next = {q_reg[12:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        if (scale)
            tq = t_reg[17] ? -18'(q_reg) : 18'(q_reg);
        else
            tq = t_reg;
        e_wide = tq - 18'(speed_reg);
    end

    // truncate toward zero, then saturate
    always_comb
    begin
        acc_adj = acc_reg + (acc_reg[40] ? 41'sd255 : 41'sd0);
        qv      = acc_adj >>> 8;
        if (qv > 41'(OutLimit))
            drive_next = 16'(OutLimit);
        else if (qv < -41'(OutLimit))
            drive_next = -16'(OutLimit);
        else
            drive_next = 16'(qv);

        if (s_reg > 19'(SumLimit))
            sum_next = 18'(SumLimit);
        else if (s_reg < -19'(SumLimit))
            sum_next = -18'(SumLimit);
        else
            sum_next = 18'(s_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            t_reg     <= t_next;
            speed_reg <= speed;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (ctrl.err)
            e_reg <= 17'(e_wide);
        if (ctrl.diff)
        begin
            s_reg  <= 19'(sum_reg) + 19'(e_reg);
            de_reg <= 18'(e_reg) - 18'(prev_reg);
        end
        if (ctrl.prod)
        begin
            pp_reg <= 37'(gains.gain_p) * 37'(e_reg);
            pi_reg <= 39'(gains.gain_i) * 39'(s_reg);
            pd_reg <= 38'(gains.gain_d) * 38'(de_reg);
        end
        if (ctrl.sum)
            acc_reg <= 41'(pp_reg) + 41'(pi_reg) + 41'(pd_reg);
        if (ctrl.fin)
            drive_reg <= drive_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            sum_reg  <= '0;
        end
        else if (ctrl.fin)
        begin
            prev_reg <= e_reg;
            sum_reg  <= sum_next;
        end
    end

    assign drive = drive_reg;

endmodule

FILE: design/mmwp_merge.sv
module mmwp_merge (
    input  logic [mmwp_pkg::Wheels-1:0][17:0] abs_t,
    output logic [17:0]                       maxabs,
    output logic                              scale
);
    import mmwp_pkg::*;

    always_comb
    begin
        maxabs = '0;
        for (int w = 0; w < Wheels; w++)
        begin
            if (abs_t[w] > maxabs)
                maxabs = abs_t[w];
        end
        scale = maxabs > 18'(TargetLimit);
    end

endmodule

FILE: dv/tb_mecanum_mix_wheel_pid_core.sv
module tb_mecanum_mix_wheel_pid_core;
    import mmwp_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    req_item_t   req;
    logic        rsp_valid;
    logic        rsp_stall;
    rsp_item_t   rsp;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mecanum_mix_wheel_pid_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    localparam logic [3:0] AddrUnused = 4'd12;

    req_item_t pending_cmd_q[$];
    rsp_item_t expected_drive_q[$];

    longint gain_p_m;
    longint gain_i_m;
    longint gain_d_m;
    longint prev_err_m[Wheels];
    longint err_sum_m[Wheels];

    int errors;
    int send_gap;
    int stall_len;
    bit calm;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 94)
            return $urandom_range(1, 4);
        return $urandom_range(15, 70);
    endfunction

    function automatic longint clamp_to(input longint v, input longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // mix, scale and run the four wheel loops for one accepted transaction
    function automatic void predict_drive(input req_item_t c);
        longint t[Wheels];
        longint spd[Wheels];
        longint f;
        longint l;
        longint y;
        longint maxabs;
        longint a;
        longint e;
        longint s;
        longint acc;
        longint q[Wheels];
        rsp_item_t d;
        f = c.cmd_forward;
        l = c.cmd_left;
        y = c.cmd_yaw;
        t[0] = longint'(c.base_one) - f + l + y;
        t[1] = longint'(c.base_two) - f - l + y;
        t[2] = longint'(c.base_three) + f + l + y;
        t[3] = longint'(c.base_four) + f - l + y;
        spd[0] = c.speed_one;
        spd[1] = c.speed_two;
        spd[2] = c.speed_three;
        spd[3] = c.speed_four;
        maxabs = 0;
        for (int w = 0; w < Wheels; w++)
        begin
            a = t[w] < 0 ? -t[w] : t[w];
            if (a > maxabs)
                maxabs = a;
        end
        if (maxabs > TargetLimit)
            for (int w = 0; w < Wheels; w++)
                t[w] = (t[w] * TargetLimit) / maxabs;
        for (int w = 0; w < Wheels; w++)
        begin
            e = t[w] - spd[w];
            s = err_sum_m[w] + e;
            acc = gain_p_m * e + gain_i_m * s + gain_d_m * (e - prev_err_m[w]);
            q[w] = clamp_to(acc / 256, OutLimit);
            prev_err_m[w] = e;
            err_sum_m[w] = clamp_to(s, SumLimit);
        end
        d.drive_one = q[0][15:0];
        d.drive_two = q[1][15:0];
        d.drive_three = q[2][15:0];
        d.drive_four = q[3][15:0];
        expected_drive_q.push_back(d);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                predict_drive(req);
            if (!req_valid || !req_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    req_valid <= 1'b0;
                end
                else if (pending_cmd_q.size() > 0)
                begin
                    req <= pending_cmd_q.pop_front();
                    req_valid <= 1'b1;
                    send_gap <= pick_gap();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            stall_len <= 0;
            calm <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 249) == 0)
                calm <= ~calm;
            if (stall_len > 0)
            begin
                rsp_stall <= 1'b1;
                stall_len <= stall_len - 1;
            end
            else
            begin
                rsp_stall <= 1'b0;
                stall_len <= pick_gap();
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        rsp_item_t x;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_drive_q.size() == 0)
                report_mismatch("result transaction with nothing expected");
            else
            begin
                x = expected_drive_q.pop_front();
                if (rsp.drive_one !== x.drive_one)
                    report_mismatch($sformatf("drive_one %0d exp %0d", rsp.drive_one,
                                              x.drive_one));
                if (rsp.drive_two !== x.drive_two)
                    report_mismatch($sformatf("drive_two %0d exp %0d", rsp.drive_two,
                                              x.drive_two));
                if (rsp.drive_three !== x.drive_three)
                    report_mismatch($sformatf("drive_three %0d exp %0d", rsp.drive_three,
                                              x.drive_three));
                if (rsp.drive_four !== x.drive_four)
                    report_mismatch($sformatf("drive_four %0d exp %0d", rsp.drive_four,
                                              x.drive_four));
            end
        end
    end

    task automatic write_gain(input logic [3:0] addr, input logic signed [GainW-1:0] g);
        logic [31:0] v;
        v = {12'($urandom), g};
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (addr[3:2])
            REG_GAIN_P: gain_p_m = longint'($signed(v[GainW-1:0]));
            REG_GAIN_I: gain_i_m = longint'($signed(v[GainW-1:0]));
            REG_GAIN_D: gain_d_m = longint'($signed(v[GainW-1:0]));
            default: ;
        endcase
    endtask

    task automatic set_gains(input int p, input int i, input int d);
        write_gain({REG_GAIN_P, 2'b00}, p[GainW-1:0]);
        write_gain({REG_GAIN_I, 2'b00}, i[GainW-1:0]);
        write_gain({REG_GAIN_D, 2'b00}, d[GainW-1:0]);
        write_gain(AddrUnused, 20'($urandom));
    endtask

    task automatic drain();
        while (pending_cmd_q.size() > 0 || req_valid || expected_drive_q.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic req_item_t fill_all(input logic [15:0] v);
        return {11{v}};
    endfunction

    function automatic logic [15:0] small_val(input int lim);
        return 16'($signed($urandom_range(0, 2 * lim)) - lim);
    endfunction

    function automatic req_item_t rand_cmd();
        req_item_t c;
        int m;
        m = $urandom_range(0, 9);
        if (m < 3)
            c = 176'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        else
        begin
            c.cmd_forward = small_val(2500);
            c.cmd_left = small_val(2500);
            c.cmd_yaw = small_val(2500);
            c.base_one = small_val(2000);
            c.base_two = small_val(2000);
            c.base_three = small_val(2000);
            c.base_four = small_val(2000);
            c.speed_one = small_val(m < 8 ? 300 : 12000);
            c.speed_two = small_val(m < 8 ? 300 : 12000);
            c.speed_three = small_val(m < 8 ? 300 : 12000);
            c.speed_four = small_val(m < 8 ? 300 : 12000);
        end
        return c;
    endfunction

    task automatic run_random(input int n);
        repeat (n) pending_cmd_q.push_back(rand_cmd());
        drain();
    endtask

    initial
    begin
        req_item_t c;
        errors = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        gain_p_m = GainPReset;
        gain_i_m = GainIReset;
        gain_d_m = GainDReset;
        for (int w = 0; w < Wheels; w++)
        begin
            prev_err_m[w] = 0;
            err_sum_m[w] = 0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: zeros, extremes, scaling, single commands, saturation
        pending_cmd_q.push_back(fill_all(16'h0000));
        pending_cmd_q.push_back(fill_all(16'h7fff));
        pending_cmd_q.push_back(fill_all(16'h8000));
        pending_cmd_q.push_back(fill_all(16'hffff));
        pending_cmd_q.push_back(fill_all(16'h0001));
        c = '0; c.cmd_forward = 16'sd10000; pending_cmd_q.push_back(c);
        c = '0; c.cmd_forward = 16'sd10001; pending_cmd_q.push_back(c);
        c = '0; c.cmd_left = -16'sd32768; pending_cmd_q.push_back(c);
        c = '0; c.cmd_yaw = 16'sd32767; pending_cmd_q.push_back(c);
        c = '0; c.base_three = 16'sd30000; c.base_one = -16'sd7; pending_cmd_q.push_back(c);
        c = '0; c.speed_two = 16'sd32767; c.speed_four = -16'sd32768;
        pending_cmd_q.push_back(c);
        c = fill_all(16'h0000); c.cmd_forward = 16'h7fff; c.cmd_left = 16'h7fff;
        c.cmd_yaw = 16'h7fff; c.base_four = 16'h7fff; c.speed_one = 16'h8000;
        pending_cmd_q.push_back(c);
        repeat (6)
        begin
            c = '0; c.cmd_forward = small_val(50); c.speed_one = small_val(50);
            pending_cmd_q.push_back(c);
        end
        drain();

        run_random(120);
        set_gains(256, 64, 128);
        run_random(130);
        set_gains(524287, 524287, 524287);
        run_random(100);
        set_gains(-524288, -524288, -524288);
        run_random(100);
        set_gains(0, 0, 0);
        run_random(50);
        set_gains(-300, 5, -1);
        run_random(130);
        set_gains(int'($urandom_range(0, 4000)), int'($urandom_range(0, 40)),
                  -int'($urandom_range(0, 4000)));
        run_random(120);

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
